>>> rtl/nfrc_pkg.sv
// shared types, constants, microprogram and saturating helpers of the root classifier
package nfrc_pkg;

	localparam logic [63:0] PHI_BITS = 64'h9E3779B97F4A7C15;
	localparam int ACC_W = 130;

	// configuration register indexes
	localparam logic [1:0] CFG_POLY_MODE  = 2'd0;
	localparam logic [1:0] CFG_ITER_COUNT = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

	localparam logic [7:0]  ITER_RESET = 8'd32;
	localparam logic [24:0] TOL_RESET  = 25'd16777;

	typedef logic signed [63:0] fx_t;

	typedef struct packed {
		fx_t re;
		fx_t im;
	} cfx_t;

	typedef struct packed {
		logic [5:0] pixel_x;
		logic [5:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [2:0] root_index;
		logic       div_zero;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [24:0] data;
	} cfg_req_t;

	typedef enum logic [2:0] {
		OP_INIT, OP_FIVE, OP_MUL, OP_SUB, OP_ADDK, OP_DIV, OP_CLASS
	} op_t;

	typedef enum logic [2:0] {
		R_Z, R_Z2, R_F, R_DF, R_T, R_Q, R_FIVE
	} reg_t;

	typedef struct packed {
		op_t               op;
		reg_t              dst;
		reg_t              src_a;
		reg_t              src_b;
		logic signed [3:0] k;
		logic              last;
	} instr_t;

	typedef struct packed {
		logic   start;
		instr_t instr;
	} dp_cmd_t;

	typedef struct packed {
		logic       done;
		logic       div_zero;
		logic [2:0] root_index;
	} dp_status_t;

	typedef enum logic [3:0] {
		C_IDLE, C_INIT, C_INIT_W, C_FIVE, C_FIVE_W, C_CHECK,
		C_STEP, C_STEP_W, C_CLASS, C_CLASS_W, C_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_IDLE, DP_MOD, DP_FETCH, DP_TERM, DP_MUL, DP_FIN, DP_DIV, DP_CLS, DP_WRITE
	} dp_phase_t;

	function automatic instr_t mk(input op_t op, input reg_t dst, input reg_t a,
		input reg_t b, input logic signed [3:0] k, input logic last);
		instr_t i;
		i.op = op;
		i.dst = dst;
		i.src_a = a;
		i.src_b = b;
		i.k = k;
		i.last = last;
		return i;
	endfunction

	// one newton step per pass through the program
	function automatic instr_t prog_instr(input logic mode, input logic [3:0] pc);
		instr_t i;
		i = mk(OP_SUB, R_Z, R_Z, R_Q, 4'sd0, 1'b1);
		if (!mode) begin
			case (pc)
			4'd0: i = mk(OP_MUL,  R_Z2, R_Z,    R_Z,  4'sd0,  1'b0);
			4'd1: i = mk(OP_ADDK, R_T,  R_Z2,   R_Z2, 4'sd1,  1'b0);
			4'd2: i = mk(OP_MUL,  R_F,  R_Z,    R_T,  4'sd0,  1'b0);
			4'd3: i = mk(OP_ADDK, R_T,  R_Z2,   R_Z2, -4'sd1, 1'b0);
			4'd4: i = mk(OP_MUL,  R_F,  R_F,    R_T,  4'sd0,  1'b0);
			4'd5: i = mk(OP_MUL,  R_T,  R_Z2,   R_Z2, 4'sd0,  1'b0);
			4'd6: i = mk(OP_MUL,  R_T,  R_FIVE, R_T,  4'sd0,  1'b0);
			4'd7: i = mk(OP_ADDK, R_DF, R_T,    R_T,  -4'sd1, 1'b0);
			4'd8: i = mk(OP_DIV,  R_Q,  R_F,    R_DF, 4'sd0,  1'b0);
			default: i = mk(OP_SUB, R_Z, R_Z, R_Q, 4'sd0, 1'b1);
			endcase
		end else begin
			case (pc)
			4'd0:  i = mk(OP_MUL,  R_Z2, R_Z,    R_Z,  4'sd0,  1'b0);
			4'd1:  i = mk(OP_ADDK, R_T,  R_Z2,   R_Z2, 4'sd1,  1'b0);
			4'd2:  i = mk(OP_MUL,  R_F,  R_Z,    R_T,  4'sd0,  1'b0);
			4'd3:  i = mk(OP_SUB,  R_T,  R_Z2,   R_Z,  4'sd0,  1'b0);
			4'd4:  i = mk(OP_ADDK, R_T,  R_T,    R_T,  -4'sd1, 1'b0);
			4'd5:  i = mk(OP_MUL,  R_F,  R_F,    R_T,  4'sd0,  1'b0);
			4'd6:  i = mk(OP_MUL,  R_T,  R_FIVE, R_Z,  4'sd0,  1'b0);
			4'd7:  i = mk(OP_ADDK, R_T,  R_T,    R_T,  -4'sd4, 1'b0);
			4'd8:  i = mk(OP_MUL,  R_T,  R_Z2,   R_T,  4'sd0,  1'b0);
			4'd9:  i = mk(OP_ADDK, R_T,  R_T,    R_T,  -4'sd2, 1'b0);
			4'd10: i = mk(OP_MUL,  R_T,  R_Z,    R_T,  4'sd0,  1'b0);
			4'd11: i = mk(OP_ADDK, R_DF, R_T,    R_T,  -4'sd1, 1'b0);
			4'd12: i = mk(OP_DIV,  R_Q,  R_F,    R_DF, 4'sd0,  1'b0);
			default: i = mk(OP_SUB, R_Z, R_Z, R_Q, 4'sd0, 1'b1);
			endcase
		end
		return i;
	endfunction

	function automatic fx_t sat_add(input fx_t a, input fx_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic fx_t sat_sub(input fx_t a, input fx_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input fx_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

>>> rtl/nfrc_stream_if.sv
// valid/ready channel carrying one request of a given payload type
interface nfrc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/nfrc_div.sv
// bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), signed and saturated
module nfrc_div #(
	parameter int FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [127:0]         num,
	input  logic                 neg,
	input  logic [127:0]         den,
	output logic                 done,
	output nfrc_pkg::fx_t        quo
);
	import nfrc_pkg::*;

	localparam int STEPS = 128 + FRAC_BITS;
	localparam int CW = $clog2(STEPS + 1);

	logic [127:0] dvd_q;
	logic [127:0] rem_q;
	logic [63:0]  q_q;
	logic         ovf_q;
	logic         neg_q;
	logic [CW-1:0] cnt_q;
	logic         busy_q;
	logic         done_q;

	logic [128:0] r_sh;
	logic         ge;
	logic [128:0] r_sub;

	assign r_sh  = {rem_q, dvd_q[127]};
	assign ge    = r_sh >= {1'b0, den};
	assign r_sub = r_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= neg;
		end else if (busy_q) begin
			// zeros shift in once the numerator is used up
			dvd_q <= {dvd_q[126:0], 1'b0};
			rem_q <= ge ? r_sub[127:0] : r_sh[127:0];
			q_q   <= {q_q[62:0], ge};
			ovf_q <= ovf_q | q_q[63];
		end
	end

	always_comb begin
		if (ovf_q || q_q[63])
			quo = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			quo = neg_q ? -fx_t'(q_q) : fx_t'(q_q);
	end

	assign done = done_q;

endmodule

>>> rtl/nfrc_datapath.sv
// datapath: complex register file, shared 32x32 multiplier, divider and root match
module nfrc_datapath #(
	parameter int GRID_SIZE = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nfrc_pkg::dp_cmd_t     cmd,
	output nfrc_pkg::dp_status_t  status,
	input  logic [5:0]            pix_x,
	input  logic [5:0]            pix_y,
	input  logic                  poly_mode,
	input  logic [24:0]           tolerance
);
	import nfrc_pkg::*;

	localparam fx_t ONE = fx_t'(1) <<< FRAC_BITS;
	localparam logic [63:0] PHI_FRAC =
		(PHI_BITS + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
	localparam int TOL_SHL = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
	localparam int TOL_SHR = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;

	dp_phase_t phase_q;
	instr_t    ins_q;
	logic [2:0] term_q;
	logic [2:0] cnt_q;
	logic [2:0] cls_k_q;
	logic [2:0] hit_q;

	cfx_t rf_q [7];
	cfx_t rd_a_q, rd_b_q;
	cfx_t wdata_q;
	reg_t ra, rb;

	logic [5:0]  vx_q, vy_q;
	logic [63:0] mx_q, my_q;
	logic        neg_q;
	logic [63:0] pp_q;
	logic [1:0]  ppsh_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [127:0] den_q;

	fx_t  op_x, op_y;
	logic op_neg;
	logic is_div;
	logic [31:0] mul_a, mul_b;
	logic [63:0] pp_d;
	logic [ACC_W-1:0] pp_ext;
	logic [ACC_W-1:0] acc_mag;
	logic [ACC_W-1:0] acc_shr;
	fx_t  fixed_d;
	logic b_zero;
	logic x_big, y_big;
	logic div_start, div_done;
	fx_t  div_quo;
	logic [63:0] tol;
	fx_t  root_re, root_im;
	logic signed [64:0] d_re, d_im;
	logic [64:0] ad_re, ad_im;
	logic match;

	assign ra = cmd.start ? cmd.instr.src_a : ins_q.src_a;
	assign rb = cmd.start ? cmd.instr.src_b : ins_q.src_b;

	always_ff @(posedge clk) begin
		rd_a_q <= rf_q[ra];
		rd_b_q <= rf_q[rb];
		if (phase_q == DP_WRITE)
			rf_q[ins_q.dst] <= wdata_q;
	end

	assign is_div = ins_q.op == OP_DIV;

	// operand pair of each real product
	always_comb begin
		op_x = rd_a_q.re;
		op_y = rd_b_q.re;
		op_neg = 1'b0;
		case (term_q)
		3'd0: begin
			if (is_div) op_x = rd_b_q.re;
		end
		3'd1: begin
			op_x = is_div ? rd_b_q.im : rd_a_q.im;
			op_y = rd_b_q.im;
			op_neg = !is_div;
		end
		3'd2: begin
			op_y = is_div ? rd_b_q.re : rd_b_q.im;
		end
		3'd3: begin
			op_x = rd_a_q.im;
			op_y = is_div ? rd_b_q.im : rd_b_q.re;
		end
		3'd4: begin
			op_x = rd_a_q.im;
		end
		3'd5: begin
			op_y = rd_b_q.im;
			op_neg = 1'b1;
		end
		default: ;
		endcase
	end

	assign mul_a  = mx_q[32*cnt_q[0] +: 32];
	assign mul_b  = my_q[32*cnt_q[1] +: 32];
	assign pp_d   = mul_a * mul_b;
	assign pp_ext = ACC_W'(pp_q) << {ppsh_q, 5'd0};

	assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign acc_shr = acc_mag >> FRAC_BITS;

	always_comb begin
		if (acc_shr[ACC_W-1:63] != '0)
			fixed_d = acc_q[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			fixed_d = acc_q[ACC_W-1] ? -fx_t'(acc_shr[63:0]) : fx_t'(acc_shr[63:0]);
	end

	assign b_zero = (rd_b_q.re == '0) && (rd_b_q.im == '0);
	assign x_big  = {3'd0, vx_q} >= 9'(GRID_SIZE);
	assign y_big  = {3'd0, vy_q} >= 9'(GRID_SIZE);

	assign div_start = (phase_q == DP_FIN) && is_div && (term_q != 3'd1);

	nfrc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_mag[127:0]),
		.neg    (acc_q[ACC_W-1]),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// root match, one root per cycle
	assign tol = (64'(tolerance) << TOL_SHL) >> TOL_SHR;

	always_comb begin
		root_re = '0;
		root_im = '0;
		case (cls_k_q)
		3'd0: root_re = poly_mode ? ONE + fx_t'(PHI_FRAC) : ONE;
		3'd1: root_re = poly_mode ? -fx_t'(PHI_FRAC) : -ONE;
		3'd3: root_im = ONE;
		3'd4: root_im = -ONE;
		default: ;
		endcase
	end

	assign d_re  = 65'(rd_a_q.re) - 65'(root_re);
	assign d_im  = 65'(rd_a_q.im) - 65'(root_im);
	assign ad_re = d_re[64] ? 65'(-d_re) : 65'(d_re);
	assign ad_im = d_im[64] ? 65'(-d_im) : 65'(d_im);
	assign match = (ad_re < {1'b0, tol}) && (ad_im < {1'b0, tol});

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DP_IDLE;
			term_q  <= '0;
			cnt_q   <= '0;
			cls_k_q <= '0;
			hit_q   <= '0;
		end else begin
			case (phase_q)
			DP_IDLE: begin
				if (cmd.start) begin
					phase_q <= (cmd.instr.op == OP_INIT) ? DP_MOD : DP_FETCH;
					term_q  <= '0;
					cls_k_q <= '0;
					if (cmd.instr.op == OP_CLASS) hit_q <= '0;
				end
			end
			DP_MOD: begin
				if (!x_big && !y_big) phase_q <= DP_WRITE;
			end
			DP_FETCH: begin
				case (ins_q.op)
				OP_MUL: phase_q <= DP_TERM;
				OP_DIV: phase_q <= b_zero ? DP_IDLE : DP_TERM;
				OP_CLASS: phase_q <= DP_CLS;
				default: phase_q <= DP_WRITE;
				endcase
			end
			DP_TERM: begin
				cnt_q   <= '0;
				phase_q <= DP_MUL;
			end
			DP_MUL: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd4) begin
					if (term_q[0]) begin
						phase_q <= DP_FIN;
					end else begin
						term_q  <= term_q + 1'b1;
						phase_q <= DP_TERM;
					end
				end
			end
			DP_FIN: begin
				if (is_div && term_q != 3'd1) begin
					phase_q <= DP_DIV;
				end else if (!is_div && term_q == 3'd3) begin
					phase_q <= DP_WRITE;
				end else begin
					term_q  <= term_q + 1'b1;
					phase_q <= DP_TERM;
				end
			end
			DP_DIV: begin
				if (div_done) begin
					if (term_q == 3'd3) begin
						term_q  <= term_q + 1'b1;
						phase_q <= DP_TERM;
					end else begin
						phase_q <= DP_WRITE;
					end
				end
			end
			DP_CLS: begin
				if (hit_q == '0 && match) hit_q <= cls_k_q + 1'b1;
				cls_k_q <= cls_k_q + 1'b1;
				if (cls_k_q == 3'd4) phase_q <= DP_IDLE;
			end
			DP_WRITE: phase_q <= DP_IDLE;
			default: phase_q <= DP_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (phase_q)
		DP_IDLE: begin
			if (cmd.start) begin
				ins_q <= cmd.instr;
				vx_q  <= pix_x;
				vy_q  <= pix_y;
			end
		end
		DP_MOD: begin
			if (x_big) vx_q <= vx_q - 6'(GRID_SIZE);
			if (y_big) vy_q <= vy_q - 6'(GRID_SIZE);
			wdata_q.re <= fx_t'(vx_q) <<< FRAC_BITS;
			wdata_q.im <= fx_t'(vy_q) <<< FRAC_BITS;
		end
		DP_FETCH: begin
			acc_q <= '0;
			case (ins_q.op)
			OP_FIVE: begin
				wdata_q.re <= fx_t'(5) <<< FRAC_BITS;
				wdata_q.im <= '0;
			end
			OP_SUB: begin
				wdata_q.re <= sat_sub(rd_a_q.re, rd_b_q.re);
				wdata_q.im <= sat_sub(rd_a_q.im, rd_b_q.im);
			end
			OP_ADDK: begin
				wdata_q.re <= sat_add(rd_a_q.re, fx_t'(ins_q.k) <<< FRAC_BITS);
				wdata_q.im <= rd_a_q.im;
			end
			default: ;
			endcase
		end
		DP_TERM: begin
			mx_q  <= mag64(op_x);
			my_q  <= mag64(op_y);
			neg_q <= op_x[63] ^ op_y[63] ^ op_neg;
		end
		DP_MUL: begin
			if (cnt_q != 3'd4) begin
				pp_q   <= pp_d;
				ppsh_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
			end
			if (cnt_q != 3'd0)
				acc_q <= neg_q ? acc_q - pp_ext : acc_q + pp_ext;
		end
		DP_FIN: begin
			if (is_div) begin
				if (term_q == 3'd1) den_q <= acc_q[127:0];
			end else if (term_q == 3'd1) begin
				wdata_q.re <= fixed_d;
			end else begin
				wdata_q.im <= fixed_d;
			end
			if (!(is_div && term_q != 3'd1)) acc_q <= '0;
		end
		DP_DIV: begin
			if (div_done) begin
				acc_q <= '0;
				if (term_q == 3'd3) wdata_q.re <= div_quo;
				else wdata_q.im <= div_quo;
			end
		end
		default: ;
		endcase
	end

	always_comb begin
		status.div_zero   = (phase_q == DP_FETCH) && is_div && b_zero;
		status.done       = (phase_q == DP_WRITE) || status.div_zero ||
			((phase_q == DP_CLS) && (cls_k_q == 3'd4));
		status.root_index = hit_q;
	end

endmodule

>>> rtl/nfrc_ctrl.sv
// controller: walks the newton step program and the per-pixel sequence
module nfrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_busy,
	input  logic                  poly_mode,
	input  logic [7:0]            iteration_count,
	input  nfrc_pkg::dp_status_t  status,
	output nfrc_pkg::dp_cmd_t     cmd,
	output logic                  res_load,
	output logic                  res_dz
);
	import nfrc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [3:0]  pc_q;
	logic [7:0]  iter_q;
	logic        dz_q;
	instr_t      step_instr;

	assign step_instr = prog_instr(poly_mode, pc_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
		C_IDLE:    if (in_valid) state_d = C_INIT;
		C_INIT:    state_d = C_INIT_W;
		C_INIT_W:  if (status.done) state_d = C_FIVE;
		C_FIVE:    state_d = C_FIVE_W;
		C_FIVE_W:  if (status.done) state_d = C_CHECK;
		C_CHECK:   state_d = (iter_q == '0) ? C_CLASS : C_STEP;
		C_STEP:    state_d = C_STEP_W;
		C_STEP_W: begin
			if (status.done) begin
				if (status.div_zero) state_d = C_CLASS;
				else if (step_instr.last) state_d = C_CHECK;
				else state_d = C_STEP;
			end
		end
		C_CLASS:   state_d = C_CLASS_W;
		C_CLASS_W: if (status.done) state_d = C_DONE;
		C_DONE:    if (!out_busy) state_d = C_IDLE;
		default:   state_d = C_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == C_IDLE;
		res_load  = (state_q == C_DONE) && !out_busy;
		res_dz    = dz_q;
		cmd.start = 1'b0;
		cmd.instr = step_instr;
		case (state_q)
		C_INIT: begin
			cmd.start = 1'b1;
			cmd.instr = mk(OP_INIT, R_Z, R_Z, R_Z, 4'sd0, 1'b0);
		end
		C_FIVE: begin
			cmd.start = 1'b1;
			cmd.instr = mk(OP_FIVE, R_FIVE, R_Z, R_Z, 4'sd0, 1'b0);
		end
		C_STEP: cmd.start = 1'b1;
		C_CLASS: begin
			cmd.start = 1'b1;
			cmd.instr = mk(OP_CLASS, R_Z, R_Z, R_Z, 4'sd0, 1'b0);
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pc_q    <= '0;
			iter_q  <= '0;
			dz_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
			C_IDLE: begin
				dz_q   <= 1'b0;
				pc_q   <= '0;
				iter_q <= iteration_count;
			end
			C_STEP_W: begin
				if (status.done) begin
					if (status.div_zero) begin
						dz_q <= 1'b1;
					end else if (step_instr.last) begin
						pc_q   <= '0;
						iter_q <= iter_q - 1'b1;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
			end
			default: ;
			endcase
		end
	end

endmodule

>>> rtl/newton_fractal_root_classifier.sv
// top level: newton iteration root classifier for one grid pixel per request
//
// pixel_in carries a request (pixel_x, pixel_y); the start point is x + iy,
// each coordinate taken modulo GRID_SIZE. result_out returns root_index
// (0 none, 1..5) and div_zero for every request, in order. cfg writes
// poly_mode, iteration_count and tolerance by index; it is always ready, and
// the user writes it only while no pixel is in flight; the block does not enforce this.
// one pixel at a time: setup (start point and the constant five),
// iteration_count newton steps, then the final check and root matching.
// the cost of a step is set by the bit-serial divider (two quotients per
// step) and by the single 32x32 multiplier (four partial products per real
// product). a zero derivative ends the steps early.
// reset clears the controller, the pending result and the registers to
// poly_mode 0, iteration_count 32, tolerance 16777.
// the result waits in an output register while result_out is stalled; the
// next request is taken meanwhile and holds in its done state until the
// register is free.
module newton_fractal_root_classifier #(
	parameter int GRID_SIZE = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	nfrc_stream_if.sink   pixel_in,
	nfrc_stream_if.source result_out,
	nfrc_stream_if.sink   cfg
);
	import nfrc_pkg::*;

	logic        poly_mode_q;
	logic [7:0]  iter_count_q;
	logic [24:0] tolerance_q;
	pixel_t      pix_q;
	result_t     res_q;
	logic        res_valid_q;

	cfg_req_t    cfg_req;
	pixel_t      pix_req;
	dp_cmd_t     cmd;
	dp_status_t  status;
	logic        in_ready;
	logic        res_load;
	logic        res_dz;

	assign cfg_req = cfg.payload;
	assign pix_req = pixel_in.payload;
	assign cfg.ready = 1'b1;
	assign pixel_in.ready = in_ready;
	assign result_out.valid = res_valid_q;
	assign result_out.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_mode_q  <= 1'b0;
			iter_count_q <= ITER_RESET;
			tolerance_q  <= TOL_RESET;
		end else if (cfg.valid) begin
			case (cfg_req.index)
			CFG_POLY_MODE:  poly_mode_q  <= cfg_req.data[0];
			CFG_ITER_COUNT: iter_count_q <= cfg_req.data[7:0];
			CFG_TOLERANCE:  tolerance_q  <= cfg_req.data;
			default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_in.valid && in_ready)
			pix_q <= pix_req;
		if (res_load) begin
			res_q.root_index <= status.root_index;
			res_q.div_zero   <= res_dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (result_out.ready)
			res_valid_q <= 1'b0;
	end

	nfrc_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (pixel_in.valid),
		.in_ready        (in_ready),
		.out_busy        (res_valid_q),
		.poly_mode       (poly_mode_q),
		.iteration_count (iter_count_q),
		.status          (status),
		.cmd             (cmd),
		.res_load        (res_load),
		.res_dz          (res_dz)
	);

	nfrc_datapath #(
		.GRID_SIZE (GRID_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pix_x     (pix_q.pixel_x),
		.pix_y     (pix_q.pixel_y),
		.poly_mode (poly_mode_q),
		.tolerance (tolerance_q)
	);

endmodule

>>> rtl/nfrc_checker.sv
// port-level checks of the root classifier and their binding to the top level
module nfrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] root_index,
	input logic       div_zero
);
	// a taken request must still pass through setup, steps and classification, so no result can appear right after it
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a request");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> root_index <= 3'd5)
		else $error("root index out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(root_index) && $stable(div_zero))
		else $error("result changed while stalled");
endmodule

bind newton_fractal_root_classifier nfrc_checker u_nfrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixel_in.valid),
	.in_ready   (pixel_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.root_index (result_out.payload.root_index),
	.div_zero   (result_out.payload.div_zero)
);

>>> tb/newton_fractal_root_classifier_tb.sv
// testbench: random and directed pixels against a fixed-point newton predictor
module newton_fractal_root_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nfrc_pkg::*;

	localparam int FB = 24;
	localparam int GRID = 64;
	localparam int WATCHDOG_LIMIT = 800000;

	class root_scoreboard;
		logic        mode;
		logic [7:0]  iters;
		logic [24:0] tol;
		result_t     expected_q[$];
		int          errors;

		function new();
			mode = 1'b0;
			iters = ITER_RESET;
			tol = TOL_RESET;
			errors = 0;
		endfunction

		function logic signed [129:0] prod(fx_t a, fx_t b);
			return 130'(a) * 130'(b);
		endfunction

		function fx_t to_fx(logic signed [129:0] v);
			logic [129:0] m;
			m = v[129] ? 130'(-v) : 130'(v);
			m = m >> FB;
			if (v[129])
				return (m >= 130'(1) << 63) ? {1'b1, 63'd0} : fx_t'(-m[63:0]);
			return (m > 130'({1'b0, {63{1'b1}}})) ? {1'b0, {63{1'b1}}} : fx_t'(m[63:0]);
		endfunction

		function fx_t sadd(fx_t a, fx_t b);
			logic signed [64:0] s;
			s = 65'(a) + 65'(b);
			if (s[64] != s[63])
				return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			return s[63:0];
		endfunction

		function fx_t ssub(fx_t a, fx_t b);
			logic signed [64:0] s;
			s = 65'(a) - 65'(b);
			if (s[64] != s[63])
				return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			return s[63:0];
		endfunction

		function cfx_t cmul(cfx_t a, cfx_t b);
			cfx_t r;
			r.re = to_fx(prod(a.re, b.re) - prod(a.im, b.im));
			r.im = to_fx(prod(a.re, b.im) + prod(a.im, b.re));
			return r;
		endfunction

		function cfx_t addk(cfx_t a, int k);
			a.re = sadd(a.re, fx_t'(k) <<< FB);
			return a;
		endfunction

		function fx_t quot(logic signed [129:0] num, logic [129:0] den);
			logic [159:0] m;
			logic [159:0] q;
			m = num[129] ? 160'(130'(-num)) : 160'(num);
			q = m / 160'(den);
			if (q >= 160'(1) << (63 - FB))
				return num[129] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			q = (m << FB) / 160'(den);
			return num[129] ? fx_t'(-q[63:0]) : fx_t'(q[63:0]);
		endfunction

		function cfx_t cdiv(cfx_t n, cfx_t d);
			logic [129:0] den;
			cfx_t r;
			den = prod(d.re, d.re) + prod(d.im, d.im);
			r.re = quot(prod(n.re, d.re) + prod(n.im, d.im), den);
			r.im = quot(prod(n.im, d.re) - prod(n.re, d.im), den);
			return r;
		endfunction

		function result_t classify_pixel(pixel_t p);
			cfx_t z, z2, f, df, t, five;
			fx_t rre[5], rim[5];
			logic [63:0] phi_frac;
			logic signed [64:0] dre, dim;
			result_t res;
			five.re = fx_t'(5) <<< FB;
			five.im = '0;
			z.re = fx_t'(p.pixel_x % GRID) <<< FB;
			z.im = fx_t'(p.pixel_y % GRID) <<< FB;
			res = '0;
			for (int k = 0; k < iters; k++) begin
				z2 = cmul(z, z);
				f = cmul(z, addk(z2, 1));
				if (!mode) begin
					f = cmul(f, addk(z2, -1));
					df = addk(cmul(five, cmul(z2, z2)), -1);
				end else begin
					t.re = ssub(z2.re, z.re);
					t.im = ssub(z2.im, z.im);
					f = cmul(f, addk(t, -1));
					t = addk(cmul(five, z), -4);
					t = addk(cmul(z2, t), -2);
					df = addk(cmul(z, t), -1);
				end
				if (df.re == 0 && df.im == 0) begin
					res.div_zero = 1'b1;
					break;
				end
				t = cdiv(f, df);
				z.re = ssub(z.re, t.re);
				z.im = ssub(z.im, t.im);
			end
			phi_frac = (PHI_BITS + (64'd1 << (63 - FB))) >> (64 - FB);
			rre[0] = mode ? (fx_t'(1) <<< FB) + fx_t'(phi_frac) : fx_t'(1) <<< FB;
			rre[1] = mode ? -fx_t'(phi_frac) : -(fx_t'(1) <<< FB);
			rim[0] = 0; rim[1] = 0;
			rre[2] = 0; rim[2] = 0;
			rre[3] = 0; rim[3] = fx_t'(1) <<< FB;
			rre[4] = 0; rim[4] = -(fx_t'(1) <<< FB);
			for (int k = 0; k < 5; k++) begin
				dre = 65'(z.re) - 65'(rre[k]);
				dim = 65'(z.im) - 65'(rim[k]);
				if (dre < 0) dre = -dre;
				if (dim < 0) dim = -dim;
				if (res.root_index == 0 && dre < 65'(tol) && dim < 65'(tol))
					res.root_index = 3'(k + 1);
			end
			return res;
		endfunction

		function void note_pixel(pixel_t p);
			expected_q.push_back(classify_pixel(p));
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result with none expected: root_index %0d div_zero %0d",
					r.root_index, r.div_zero);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (r.root_index !== e.root_index) begin
				$error("root_index expected %0d actual %0d", e.root_index, r.root_index);
				errors++;
			end
			if (r.div_zero !== e.div_zero) begin
				$error("div_zero expected %0d actual %0d", e.div_zero, r.div_zero);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	root_scoreboard sb;
	int idle_pct, stall_pct, hold_cycles, quiet_cycles;

	nfrc_stream_if #(.payload_t(pixel_t))   pixel_if();
	nfrc_stream_if #(.payload_t(result_t))  result_if();
	nfrc_stream_if #(.payload_t(cfg_req_t)) cfg_if();

	newton_fractal_root_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_in(pixel_if.sink),
		.result_out(result_if.source),
		.cfg(cfg_if.sink)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// monitor: all three channels and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (pixel_if.valid && pixel_if.ready) begin
				sb.note_pixel(pixel_if.payload);
				quiet_cycles = 0;
			end
			if (result_if.valid && result_if.ready) begin
				sb.check_result(result_if.payload);
				quiet_cycles = 0;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.payload.index)
				CFG_POLY_MODE:  sb.mode = cfg_if.payload.data[0];
				CFG_ITER_COUNT: sb.iters = cfg_if.payload.data[7:0];
				CFG_TOLERANCE:  sb.tol = cfg_if.payload.data;
				default: ;
				endcase
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver with random stalls and requested long hold-offs
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_if.ready = 1'b0;
			hold_cycles--;
		end else begin
			result_if.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_pixel(input logic [5:0] x, input logic [5:0] y);
		while ($urandom_range(0, 99) < idle_pct) begin
			pixel_if.valid = 1'b0;
			@(negedge clk);
		end
		pixel_if.valid = 1'b1;
		pixel_if.payload.pixel_x = x;
		pixel_if.payload.pixel_y = y;
		@(posedge clk);
		while (!pixel_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_if.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [24:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.payload.index = idx;
		cfg_if.payload.data = data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_config(input logic m, input logic [7:0] it, input logic [24:0] tl);
		drain();
		write_reg(CFG_POLY_MODE, 25'(m));
		write_reg(CFG_ITER_COUNT, 25'(it));
		write_reg(CFG_TOLERANCE, tl);
	endtask

	task automatic random_pixels(input int n);
		logic [5:0] x, y;
		for (int i = 0; i < n; i++) begin
			// mostly starts near the roots so that many converge
			x = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom);
			y = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom);
			send_pixel(x, y);
		end
	endtask

	task automatic run_phase(input logic m, input logic [7:0] it, input logic [24:0] tl,
		input int n, input int idle, input int stall);
		set_config(m, it, tl);
		idle_pct = idle;
		stall_pct = stall;
		random_pixels(n);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		pixel_if.valid = 1'b0;
		pixel_if.payload = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset settings, then zero steps so the start point itself is classified
		send_pixel(6'd1, 6'd0);
		send_pixel(6'd63, 6'd63);
		set_config(1'b0, 8'd0, 25'd16777);
		send_pixel(6'd0, 6'd0);
		send_pixel(6'd1, 6'd0);
		send_pixel(6'd0, 6'd1);
		send_pixel(6'd63, 6'd0);
		send_pixel(6'd0, 6'd63);
		set_config(1'b1, 8'd0, 25'h1FFFFFF);
		send_pixel(6'd0, 6'd0);
		send_pixel(6'd2, 6'd0);
		send_pixel(6'd42, 6'd21);
		set_config(1'b1, 8'd8, 25'd16777216);
		send_pixel(6'd2, 6'd0);
		send_pixel(6'd0, 6'd1);
		send_pixel(6'd1, 6'd1);
		send_pixel(6'd63, 6'd63);
		set_config(1'b0, 8'd8, 25'd0);
		send_pixel(6'd1, 6'd0);
		send_pixel(6'd21, 6'd42);

		run_phase(1'b0, 8'd1, 25'd16777216, 40, 0, 0);
		run_phase(1'b1, 8'd3, 25'h1FFFFFF, 40, 65, 0);
		run_phase(1'b0, 8'd12, 25'd16777, 10, 0, 65);
		// long receiver hold-off while the sender keeps offering
		hold_cycles = 20000;
		random_pixels(20);
		run_phase(1'b1, 8'd12, 25'd1000000, 30, 23, 23);
		run_phase(1'b0, 8'd6, 25'd0, 30, 0, 0);
		run_phase(1'b1, 8'd16, 25'd16777, 20, 0, 65);
		run_phase(1'b0, 8'd2, 25'd8000000, 40, 23, 23);

		set_config(1'b1, 8'd255, 25'd16777);
		idle_pct = 0;
		stall_pct = 0;
		send_pixel(6'd3, 6'd2);
		send_pixel(6'd63, 6'd1);

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
